// File: hw/rtl/fse_pkg.sv
package fse_pkg;

    // Word and field widths
    localparam int WORD_W         = 64;
    localparam int BYTE_W         = 8;
    localparam int VB_W           = 4;
    localparam int BYTES_PER_WORD = WORD_W / BYTE_W;

    // Accumulator widths and their saturation points
    localparam int INTER_W    = 12;
    localparam int UNION_W    = 12;
    localparam int WEIGHT_W   = 13;
    localparam int BYTE_CNT_W = 13;
    localparam logic [INTER_W-1:0]  INTER_MAX  = {INTER_W{1'b1}};
    localparam logic [UNION_W-1:0]  UNION_MAX  = {UNION_W{1'b1}};
    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = {WEIGHT_W{1'b1}};

    // Popcount of one byte and of the weight of one byte pair
    localparam int PC_W  = 4;
    localparam int WPC_W = PC_W + 1;

    // Divider remainder holds twice the largest denominator
    localparam int REM_W = WEIGHT_W + 1;

    // Defaults for the top-level parameters
    localparam int MAX_BYTES_DEF = 256;
    localparam int FRAC_BITS_DEF = 16;

    // Metric codes
    localparam logic METRIC_TANIMOTO = 1'b0;
    localparam logic METRIC_DICE     = 1'b1;

    // Count the set bits of one byte
    function automatic logic [PC_W-1:0] popcount8(input logic [BYTE_W-1:0] v);
        logic [PC_W-1:0] n;
        n = '0;
        for (int i = 0; i < BYTE_W; i++)
        begin
            n = n + PC_W'(v[i]);
        end
        return n;
    endfunction

endpackage

// File: hw/rtl/fse_if.sv
// Input words: one 64-bit word of each fingerprint per handshake
interface fse_word_if;
    logic                            valid;
    logic                            ready;
    logic [fse_pkg::WORD_W-1:0]      word_a;
    logic [fse_pkg::WORD_W-1:0]      word_b;
    logic [fse_pkg::VB_W-1:0]        valid_bytes;
    logic                            last;

    modport source (output valid, word_a, word_b, valid_bytes, last, input ready);
    modport sink   (input valid, word_a, word_b, valid_bytes, last, output ready);
endinterface

// Result words: one per fingerprint pair
interface fse_result_if #(
    parameter int SIM_W = fse_pkg::FRAC_BITS_DEF + 1
);
    logic                            valid;
    logic                            ready;
    logic [SIM_W-1:0]                similarity;
    logic [fse_pkg::INTER_W-1:0]     intersection_count;
    logic [fse_pkg::UNION_W-1:0]     union_count;
    logic [fse_pkg::WEIGHT_W-1:0]    weight_sum;
    logic                            overflow;

    modport source (output valid, similarity, intersection_count, union_count,
                    weight_sum, overflow, input ready);
    modport sink   (input valid, similarity, intersection_count, union_count,
                    weight_sum, overflow, output ready);
endinterface

// Configuration writes: the metric select register
interface fse_cfg_if;
    logic valid;
    logic ready;
    logic metric_select;

    modport source (output valid, metric_select, input ready);
    modport sink   (input valid, metric_select, output ready);
endinterface

// File: hw/rtl/fingerprint_similarity_engine_unit.sv
// Tanimoto / Dice similarity of two bit-vector fingerprints streamed as 64-bit word pairs.
// An input word with n valid bytes (values above eight count as eight) is counted one byte per
// cycle by a single byte popcount unit, and the block takes no new word until those n bytes
// are counted. On the word marked last the block then passes through a setup state, a bit-serial
// compare-subtract divider (skipped when the denominator is zero) and a load of the result
// register; a finished result waits there without blocking new words, and the next result is
// held back until it has been taken. Bytes beyond MAX_BYTES per pair and counts beyond their
// width saturate and raise the overflow bit of that result.
module fingerprint_similarity_engine_unit #(
    parameter int MAX_BYTES = fse_pkg::MAX_BYTES_DEF,
    parameter int FRAC_BITS = fse_pkg::FRAC_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    fse_word_if.sink        words,
    fse_result_if.source    result,
    fse_cfg_if.sink         cfg
);

    localparam int SIM_W  = FRAC_BITS + 1;
    localparam int STEP_W = $clog2(FRAC_BITS + 1);
    localparam int INTER_SUM_W  = fse_pkg::INTER_W + 1;
    localparam int UNION_SUM_W  = fse_pkg::UNION_W + 1;
    localparam int WEIGHT_SUM_W = fse_pkg::WEIGHT_W + 1;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_COUNT  = 5'b00010,
        S_SETUP  = 5'b00100,
        S_DIVIDE = 5'b01000,
        S_EMIT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic                               metric_reg, metric_next;
    logic [fse_pkg::INTER_W-1:0]        inter_reg, inter_next;
    logic [fse_pkg::UNION_W-1:0]        union_reg, union_next;
    logic [fse_pkg::WEIGHT_W-1:0]       weight_reg, weight_next;
    logic [fse_pkg::BYTE_CNT_W-1:0]     byte_cnt_reg, byte_cnt_next;
    logic                               ovf_reg, ovf_next;

    logic [fse_pkg::WORD_W-1:0]         word_a_reg, word_a_next;
    logic [fse_pkg::WORD_W-1:0]         word_b_reg, word_b_next;
    logic [fse_pkg::VB_W-1:0]           bytes_left_reg, bytes_left_next;
    logic                               last_reg, last_next;

    logic [fse_pkg::REM_W-1:0]          rem_reg, rem_next;
    logic [fse_pkg::WEIGHT_W-1:0]       den_reg, den_next;
    logic [SIM_W-1:0]                   quo_reg, quo_next;
    logic [STEP_W-1:0]                  step_reg, step_next;

    logic                               res_valid_reg, res_valid_next;
    logic [SIM_W-1:0]                   res_sim_reg, res_sim_next;
    logic [fse_pkg::INTER_W-1:0]        res_inter_reg, res_inter_next;
    logic [fse_pkg::UNION_W-1:0]        res_union_reg, res_union_next;
    logic [fse_pkg::WEIGHT_W-1:0]       res_weight_reg, res_weight_next;
    logic                               res_ovf_reg, res_ovf_next;

    // Byte popcount unit
    logic [fse_pkg::BYTE_W-1:0]         byte_a, byte_b;
    logic [fse_pkg::PC_W-1:0]           pc_and, pc_or, pc_a, pc_b;
    logic [fse_pkg::WPC_W-1:0]          pc_w;
    logic [INTER_SUM_W-1:0]             inter_sum;
    logic [UNION_SUM_W-1:0]             union_sum;
    logic [WEIGHT_SUM_W-1:0]            weight_sum;

    // Compare-subtract unit
    logic [fse_pkg::REM_W-1:0]          den_ext, diff;
    logic                               ge;
    logic [fse_pkg::REM_W-1:0]          rem_kept;

    logic [fse_pkg::VB_W-1:0]           nbytes;
    logic                               emit_go;
    logic [fse_pkg::WEIGHT_W-1:0]       num_sel, den_sel;

    assign byte_a = word_a_reg[fse_pkg::BYTE_W-1:0];
    assign byte_b = word_b_reg[fse_pkg::BYTE_W-1:0];
    assign pc_and = fse_pkg::popcount8(byte_a & byte_b);
    assign pc_or  = fse_pkg::popcount8(byte_a | byte_b);
    assign pc_a   = fse_pkg::popcount8(byte_a);
    assign pc_b   = fse_pkg::popcount8(byte_b);
    assign pc_w   = fse_pkg::WPC_W'(pc_a) + fse_pkg::WPC_W'(pc_b);

    assign inter_sum  = INTER_SUM_W'(inter_reg) + INTER_SUM_W'(pc_and);
    assign union_sum  = UNION_SUM_W'(union_reg) + UNION_SUM_W'(pc_or);
    assign weight_sum = WEIGHT_SUM_W'(weight_reg) + WEIGHT_SUM_W'(pc_w);

    assign den_ext  = fse_pkg::REM_W'(den_reg);
    assign ge       = (rem_reg >= den_ext);
    assign diff     = rem_reg - den_ext;
    assign rem_kept = ge ? diff : rem_reg;

    // Clamp the byte count of the incoming word to one word
    assign nbytes = (words.valid_bytes > fse_pkg::VB_W'(fse_pkg::BYTES_PER_WORD))
                    ? fse_pkg::VB_W'(fse_pkg::BYTES_PER_WORD) : words.valid_bytes;

    // Numerator and denominator of the selected metric
    assign num_sel = (metric_reg == fse_pkg::METRIC_DICE)
                     ? {inter_reg, 1'b0} : fse_pkg::WEIGHT_W'(inter_reg);
    assign den_sel = (metric_reg == fse_pkg::METRIC_DICE)
                     ? weight_reg : fse_pkg::WEIGHT_W'(union_reg);

    assign emit_go = !res_valid_reg || result.ready;

    assign words.ready = (state_reg == S_IDLE);
    assign cfg.ready   = 1'b1;

    assign result.valid              = res_valid_reg;
    assign result.similarity         = res_sim_reg;
    assign result.intersection_count = res_inter_reg;
    assign result.union_count        = res_union_reg;
    assign result.weight_sum         = res_weight_reg;
    assign result.overflow           = res_ovf_reg;

    always_comb
    begin
        state_next      = state_reg;
        metric_next     = metric_reg;
        inter_next      = inter_reg;
        union_next      = union_reg;
        weight_next     = weight_reg;
        byte_cnt_next   = byte_cnt_reg;
        ovf_next        = ovf_reg;
        word_a_next     = word_a_reg;
        word_b_next     = word_b_reg;
        bytes_left_next = bytes_left_reg;
        last_next       = last_reg;
        rem_next        = rem_reg;
        den_next        = den_reg;
        quo_next        = quo_reg;
        step_next       = step_reg;
        res_valid_next  = res_valid_reg;
        res_sim_next    = res_sim_reg;
        res_inter_next  = res_inter_reg;
        res_union_next  = res_union_reg;
        res_weight_next = res_weight_reg;
        res_ovf_next    = res_ovf_reg;

        // Drop the result word once taken
        if (result.ready)
        begin
            res_valid_next = 1'b0;
        end

        // Take configuration writes
        if (cfg.valid)
        begin
            metric_next = cfg.metric_select;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (words.valid)
                begin
                    word_a_next     = words.word_a;
                    word_b_next     = words.word_b;
                    bytes_left_next = nbytes;
                    last_next       = words.last;
                    if (nbytes != '0)
                    begin
                        state_next = S_COUNT;
                    end
                    else if (words.last)
                    begin
                        state_next = S_SETUP;
                    end
                end
            end

            S_COUNT:
            begin
                // Count one byte pair, or flag it when the pair is full
                if (byte_cnt_reg < fse_pkg::BYTE_CNT_W'(MAX_BYTES))
                begin
                    byte_cnt_next = byte_cnt_reg + fse_pkg::BYTE_CNT_W'(1);
                    if (inter_sum > INTER_SUM_W'(fse_pkg::INTER_MAX))
                    begin
                        inter_next = fse_pkg::INTER_MAX;
                        ovf_next   = 1'b1;
                    end
                    else
                    begin
                        inter_next = inter_sum[fse_pkg::INTER_W-1:0];
                    end
                    if (union_sum > UNION_SUM_W'(fse_pkg::UNION_MAX))
                    begin
                        union_next = fse_pkg::UNION_MAX;
                        ovf_next   = 1'b1;
                    end
                    else
                    begin
                        union_next = union_sum[fse_pkg::UNION_W-1:0];
                    end
                    if (weight_sum > WEIGHT_SUM_W'(fse_pkg::WEIGHT_MAX))
                    begin
                        weight_next = fse_pkg::WEIGHT_MAX;
                        ovf_next    = 1'b1;
                    end
                    else
                    begin
                        weight_next = weight_sum[fse_pkg::WEIGHT_W-1:0];
                    end
                end
                else
                begin
                    ovf_next = 1'b1;
                end

                // Advance to the next byte
                word_a_next     = word_a_reg >> fse_pkg::BYTE_W;
                word_b_next     = word_b_reg >> fse_pkg::BYTE_W;
                bytes_left_next = bytes_left_reg - fse_pkg::VB_W'(1);
                if (bytes_left_reg == fse_pkg::VB_W'(1))
                begin
                    state_next = last_reg ? S_SETUP : S_IDLE;
                end
            end

            S_SETUP:
            begin
                // Load the divider, or settle an empty pair at once
                rem_next  = fse_pkg::REM_W'(num_sel);
                den_next  = den_sel;
                step_next = '0;
                if (den_sel == '0)
                begin
                    quo_next   = (metric_reg == fse_pkg::METRIC_DICE)
                                 ? '0 : {1'b1, {FRAC_BITS{1'b0}}};
                    state_next = S_EMIT;
                end
                else
                begin
                    quo_next   = '0;
                    state_next = S_DIVIDE;
                end
            end

            S_DIVIDE:
            begin
                // One quotient bit per cycle
                quo_next  = {quo_reg[SIM_W-2:0], ge};
                rem_next  = rem_kept << 1;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(FRAC_BITS))
                begin
                    state_next = S_EMIT;
                end
            end

            S_EMIT:
            begin
                // Hold until the result register is free, then clear the pair
                if (emit_go)
                begin
                    res_valid_next  = 1'b1;
                    res_sim_next    = quo_reg;
                    res_inter_next  = inter_reg;
                    res_union_next  = union_reg;
                    res_weight_next = weight_reg;
                    res_ovf_next    = ovf_reg;
                    inter_next      = '0;
                    union_next      = '0;
                    weight_next     = '0;
                    byte_cnt_next   = '0;
                    ovf_next        = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            metric_reg     <= fse_pkg::METRIC_TANIMOTO;
            inter_reg      <= '0;
            union_reg      <= '0;
            weight_reg     <= '0;
            byte_cnt_reg   <= '0;
            ovf_reg        <= 1'b0;
            bytes_left_reg <= '0;
            step_reg       <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            metric_reg     <= metric_next;
            inter_reg      <= inter_next;
            union_reg      <= union_next;
            weight_reg     <= weight_next;
            byte_cnt_reg   <= byte_cnt_next;
            ovf_reg        <= ovf_next;
            bytes_left_reg <= bytes_left_next;
            step_reg       <= step_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        word_a_reg     <= word_a_next;
        word_b_reg     <= word_b_next;
        last_reg       <= last_next;
        rem_reg        <= rem_next;
        den_reg        <= den_next;
        quo_reg        <= quo_next;
        res_sim_reg    <= res_sim_next;
        res_inter_reg  <= res_inter_next;
        res_union_reg  <= res_union_next;
        res_weight_reg <= res_weight_next;
        res_ovf_reg    <= res_ovf_next;
    end

endmodule

// File: hw/rtl/fse_checker.sv
module fse_checker #(
    parameter int FRAC_BITS = fse_pkg::FRAC_BITS_DEF
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             res_valid,
    input logic                             res_ready,
    input logic [FRAC_BITS:0]               similarity,
    input logic [fse_pkg::INTER_W-1:0]      intersection_count,
    input logic [fse_pkg::UNION_W-1:0]      union_count,
    input logic [fse_pkg::WEIGHT_W-1:0]     weight_sum
);

    localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // A stalled result word stays offered
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result word dropped while stalled");

    // Common bits never outnumber the union
    a_inter_le_union: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (intersection_count <= union_count))
        else $error("intersection exceeds union");

    // Twice the common bits never exceed the weight sum
    a_inter_le_weight: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ({1'b0, intersection_count, 1'b0} <= {1'b0, weight_sum}))
        else $error("intersection exceeds half the weight sum");

    // Similarity never exceeds one
    a_sim_le_one: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (similarity <= ONE))
        else $error("similarity above one");

endmodule

bind fingerprint_similarity_engine_unit fse_checker #(
    .FRAC_BITS (FRAC_BITS)
) u_fse_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .res_valid          (result.valid),
    .res_ready          (result.ready),
    .similarity         (result.similarity),
    .intersection_count (result.intersection_count),
    .union_count        (result.union_count),
    .weight_sum         (result.weight_sum)
);
